>>> sv/bfa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bitmap frame allocator.
// ---------------------------------------------------------------------------
package bfa_pkg;

  localparam int WORD_BITS   = 32;
  localparam int OFF_W       = 5;
  localparam int FC_W        = 11;
  localparam int START_W     = 10;
  localparam int END_W       = 11;
  localparam int REQ_W       = 23;
  localparam int FRAME_NUM_W = 10;
  localparam int BYTES_W     = 24;

  localparam logic [FC_W-1:0] FC_RESET = 11'd1024;

  // register index taken from paddr[2]
  localparam logic REG_FRAME_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ACT_QUERY = 2'd0,
    ACT_MARK  = 2'd1,
    ACT_ALLOC = 2'd2,
    ACT_RUN   = 2'd3
  } action_t;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_CLEAR   = 8'b0000_0010,
    ST_CALC    = 8'b0000_0100,
    ST_FETCH   = 8'b0000_1000,
    ST_SCAN    = 8'b0001_0000,
    ST_MARK_RD = 8'b0010_0000,
    ST_MARK_WR = 8'b0100_0000,
    ST_OUT     = 8'b1000_0000
  } state_t;

endpackage

>>> sv/bfa_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfa_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/bitmap_frame_allocator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bitmap_frame_allocator
// Used-frame bitmap with query, range mark, next-fit single-frame and
// first-fit contiguous-run allocation.
// ---------------------------------------------------------------------------
// The used map sits in a one-write, one-read word RAM (32 frames per word,
// registered read) and every search goes through one shared find-first-bit
// unit under a small sequencer, one transaction at a time. After reset a
// clearing pass writes MAX_FRAMES/32 words with in_stall high. A query reads
// one word; a mark reads and rewrites each word touched; a single-frame
// allocation reads each word scanned, then reads and rewrites the word
// marked (the start word is read twice when the scan wraps); a run
// allocation adds a step for the frame count of the request and a scan step
// per free/used boundary crossed. Every transaction starts with the idle
// state that accepts it and ends by loading the output register; that last
// step waits while the register still holds an earlier result and out_stall
// is high.
// ---------------------------------------------------------------------------
module bitmap_frame_allocator
  import bfa_pkg::*;
#(
  parameter int MAX_FRAMES  = 1024,
  parameter int FRAME_BYTES = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_action,
  input  logic [START_W-1:0]     in_start_frame,
  input  logic [END_W-1:0]       in_end_frame,
  input  logic                   in_mark_value,
  input  logic [REQ_W-1:0]       in_request_bytes,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_found,
  output logic [FRAME_NUM_W-1:0] out_frame_number,
  output logic                   out_frame_bit,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int IW        = $clog2(MAX_FRAMES);
  localparam int CW        = $clog2(MAX_FRAMES + 1);
  localparam int XW        = (CW > FC_W) ? CW : FC_W;
  localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  localparam int FBW = $clog2(FRAME_BYTES);
  localparam int SH  = BYTES_W + FBW;
  localparam int RW  = BYTES_W + 1;
  localparam int PW  = BYTES_W + RW;
  localparam int NW  = BYTES_W + 1 - FBW;
  localparam longint unsigned RECIP = ((64'd1 << SH) + FRAME_BYTES - 1) / FRAME_BYTES;

  localparam logic [RW-1:0]      RECIP_C    = RW'(RECIP);
  localparam logic [XW-1:0]      MAX_X      = XW'(MAX_FRAMES);
  localparam logic [XW-1:0]      WORD_X     = XW'(WORD_BITS);
  localparam logic [XW-1:0]      BASE_MASK  = ~XW'(WORD_BITS - 1);
  localparam logic [WAW-1:0]     LAST_WORD  = WAW'(MAP_WORDS - 1);
  localparam logic [BYTES_W-1:0] ROUND_UP   = BYTES_W'(FRAME_BYTES - 1);
  localparam logic [OFF_W-1:0]   LAST_BIT   = OFF_W'(WORD_BITS - 1);

  state_t               state_r, state_nxt;
  logic [WAW-1:0]       clr_r, clr_nxt;
  action_t              act_r, act_nxt;
  logic [XW-1:0]        pos_r, pos_nxt;
  logic [XW-1:0]        hi_r, hi_nxt;
  logic [XW-1:0]        cur_r, cur_nxt;
  logic                 phase_r, phase_nxt;
  logic                 cnt_r, cnt_nxt;
  logic [XW-1:0]        begin_r, begin_nxt;
  logic [NW-1:0]        need_r, need_nxt;
  logic [BYTES_W-1:0]   n_r, n_nxt;
  logic                 mval_r, mval_nxt;
  logic [IW-1:0]        np_r, np_nxt;
  logic [FC_W-1:0]      fc_r, fc_nxt;
  logic                 res_found_r, res_found_nxt;
  logic [FRAME_NUM_W-1:0] res_frame_r, res_frame_nxt;
  logic                 res_bit_r, res_bit_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [FRAME_NUM_W-1:0] out_frame_r, out_frame_nxt;
  logic                 out_bit_r, out_bit_nxt;

  // word ram
  logic                 ram_we;
  logic [WAW-1:0]       ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WAW-1:0]       ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // datapath
  logic [XW-1:0]        fc_eff;
  logic [XW-1:0]        base;
  logic [XW-1:0]        next_base;
  logic [XW-1:0]        hi_diff;
  logic [WORD_BITS-1:0] hi_keep;
  logic [WORD_BITS-1:0] lo_keep;
  logic [WORD_BITS-1:0] scan_word;
  logic [OFF_W-1:0]     off;
  logic                 tgt;
  logic [WORD_BITS-1:0] srch;
  logic                 hit;
  logic [OFF_W-1:0]     hit_idx;
  logic [XW-1:0]        hit_pos;
  logic [PW-1:0]        prod;
  logic [XW-1:0]        end_x;
  logic [XW-1:0]        start_x;
  logic [XW-1:0]        cur_sel;
  logic [XW-1:0]        run_len;
  logic                 cfg_wr;

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_frame_number = out_frame_r;
  assign out_frame_bit    = out_bit_r;
  assign pready           = 1'b1;
  assign prdata           = (paddr[2] == REG_FRAME_COUNT) ? 32'(fc_r) : 32'd0;
  assign cfg_wr           = psel & penable & pwrite & (paddr[2] == REG_FRAME_COUNT);

  assign fc_eff    = (XW'(fc_r) > MAX_X) ? MAX_X : XW'(fc_r);
  assign start_x   = XW'(in_start_frame);
  assign end_x     = (XW'(in_end_frame) > MAX_X) ? MAX_X : XW'(in_end_frame);
  assign cur_sel   = (XW'(np_r) < fc_eff) ? XW'(np_r) : '0;

  assign base      = pos_r & BASE_MASK;
  assign next_base = base + WORD_X;
  assign off       = pos_r[OFF_W-1:0];
  assign hi_diff   = hi_r - base;
  assign hi_keep   = (hi_diff >= WORD_X) ? '1 :
                     ((WORD_BITS'(1) << hi_diff[OFF_W-1:0]) - WORD_BITS'(1));
  assign lo_keep   = {WORD_BITS{1'b1}} << off;

  // frames at or past the range end read as used
  assign scan_word = ram_rdata | ~hi_keep;

  // shared find-first unit: lowest bit at or above off that equals tgt
  assign tgt  = (act_r == ACT_RUN) && cnt_r;
  assign srch = (tgt ? scan_word : ~scan_word) & lo_keep;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (srch[i]) begin
        hit     = 1'b1;
        hit_idx = OFF_W'(i);
      end
    end
  end

  assign hit_pos = base + XW'(hit_idx);
  assign run_len = (hit ? hit_pos : next_base) - begin_r;
  assign prod    = PW'(n_r) * PW'(RECIP_C);

  assign ram_raddr = WAW'(pos_r >> OFF_W);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    act_nxt       = act_r;
    pos_nxt       = pos_r;
    hi_nxt        = hi_r;
    cur_nxt       = cur_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    begin_nxt     = begin_r;
    need_nxt      = need_r;
    n_nxt         = n_r;
    mval_nxt      = mval_r;
    np_nxt        = np_r;
    fc_nxt        = fc_r;
    res_found_nxt = res_found_r;
    res_frame_nxt = res_frame_r;
    res_bit_nxt   = res_bit_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_found_nxt = out_found_r;
    out_frame_nxt = out_frame_r;
    out_bit_nxt   = out_bit_r;
    ram_we        = 1'b0;
    ram_waddr     = WAW'(pos_r >> OFF_W);
    ram_wdata     = '0;
    ram_re        = 1'b0;

    if (cfg_wr) begin
      fc_nxt = pwdata[FC_W-1:0];
    end

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + WAW'(1);
        if (clr_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          act_nxt       = action_t'(in_action);
          res_found_nxt = 1'b0;
          res_frame_nxt = '0;
          res_bit_nxt   = 1'b0;
          state_nxt     = ST_OUT;
          case (action_t'(in_action))
            ACT_QUERY: begin
              if (start_x < MAX_X) begin
                pos_nxt   = start_x;
                hi_nxt    = MAX_X;
                state_nxt = ST_FETCH;
              end
            end
            ACT_MARK: begin
              if (start_x < end_x) begin
                pos_nxt   = start_x;
                hi_nxt    = end_x;
                mval_nxt  = in_mark_value;
                np_nxt    = IW'(end_x - XW'(1));
                state_nxt = ST_MARK_RD;
              end
            end
            ACT_ALLOC: begin
              if (fc_eff != '0) begin
                pos_nxt   = cur_sel;
                cur_nxt   = cur_sel;
                hi_nxt    = fc_eff;
                phase_nxt = 1'b0;
                state_nxt = ST_FETCH;
              end
            end
            default: begin
              n_nxt = BYTES_W'(in_request_bytes) + ROUND_UP;
              if (XW'(np_r) < fc_eff) begin
                pos_nxt   = XW'(np_r);
                hi_nxt    = fc_eff;
                cnt_nxt   = 1'b0;
                state_nxt = ST_CALC;
              end
            end
          endcase
        end
      end

      ST_CALC: begin
        need_nxt  = NW'(prod >> SH);
        state_nxt = ST_FETCH;
      end

      ST_FETCH: begin
        ram_re    = 1'b1;
        state_nxt = ST_SCAN;
      end

      ST_SCAN: begin
        state_nxt = ST_OUT;
        case (act_r)
          ACT_QUERY: begin
            res_bit_nxt = ram_rdata[off];
          end
          ACT_ALLOC: begin
            if (hit) begin
              res_found_nxt = 1'b1;
              res_frame_nxt = FRAME_NUM_W'(hit_pos);
              np_nxt        = IW'(hit_pos);
              pos_nxt       = hit_pos;
              hi_nxt        = hit_pos + XW'(1);
              mval_nxt      = 1'b1;
              state_nxt     = ST_MARK_RD;
            end else if (next_base >= hi_r) begin
              if (!phase_r && cur_r != '0) begin
                phase_nxt = 1'b1;
                pos_nxt   = '0;
                hi_nxt    = cur_r;
                state_nxt = ST_FETCH;
              end
            end else begin
              pos_nxt   = next_base;
              state_nxt = ST_FETCH;
            end
          end
          ACT_RUN: begin
            if (!cnt_r) begin
              if (hit) begin
                begin_nxt = hit_pos;
                pos_nxt   = hit_pos;
                cnt_nxt   = 1'b1;
                state_nxt = ST_SCAN;
              end else if (next_base < hi_r) begin
                pos_nxt   = next_base;
                state_nxt = ST_FETCH;
              end
            end else if (32'(run_len) >= 32'(need_r)) begin
              res_found_nxt = 1'b1;
              res_frame_nxt = FRAME_NUM_W'(begin_r);
              if (need_r != '0) begin
                pos_nxt   = begin_r;
                hi_nxt    = XW'(32'(begin_r) + 32'(need_r));
                mval_nxt  = 1'b1;
                np_nxt    = IW'(32'(begin_r) + 32'(need_r) - 32'd1);
                state_nxt = ST_MARK_RD;
              end
            end else if (hit) begin
              if (hit_pos + XW'(1) < hi_r) begin
                cnt_nxt   = 1'b0;
                pos_nxt   = hit_pos + XW'(1);
                state_nxt = (hit_idx == LAST_BIT) ? ST_FETCH : ST_SCAN;
              end
            end else if (next_base < hi_r) begin
              pos_nxt   = next_base;
              state_nxt = ST_FETCH;
            end
          end
          default: begin
            state_nxt = ST_OUT;
          end
        endcase
      end

      ST_MARK_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_MARK_WR;
      end

      ST_MARK_WR: begin
        ram_we    = 1'b1;
        ram_wdata = mval_r ? (ram_rdata | (lo_keep & hi_keep)) :
                             (ram_rdata & ~(lo_keep & hi_keep));
        if (next_base >= hi_r) begin
          state_nxt = ST_OUT;
        end else begin
          pos_nxt   = next_base;
          state_nxt = ST_MARK_RD;
        end
      end

      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_frame_nxt = res_frame_r;
          out_bit_nxt   = res_bit_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      np_r        <= '0;
      fc_r        <= FC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      np_r        <= np_nxt;
      fc_r        <= fc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    pos_r       <= pos_nxt;
    hi_r        <= hi_nxt;
    cur_r       <= cur_nxt;
    phase_r     <= phase_nxt;
    cnt_r       <= cnt_nxt;
    begin_r     <= begin_nxt;
    need_r      <= need_nxt;
    n_r         <= n_nxt;
    mval_r      <= mval_nxt;
    res_found_r <= res_found_nxt;
    res_frame_r <= res_frame_nxt;
    res_bit_r   <= res_bit_nxt;
    out_found_r <= out_found_nxt;
    out_frame_r <= out_frame_nxt;
    out_bit_r   <= out_bit_nxt;
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking testbench for the bitmap frame allocator. A behavioral copy
// of the used map and next pointer predicts each result from the accepted
// request; results are compared in order, field by field. Directed requests
// cover the field extremes and frame count corner cases, then random
// traffic runs in four idle/stall phases, two with a random frame count.
// ---------------------------------------------------------------------------
module tb;
  import bfa_pkg::*;

  localparam int MAX_FRAMES  = 1024;
  localparam int FRAME_BYTES = 4096;
  localparam int CYCLE_LIMIT = 6000000;

  typedef struct packed {
    logic                   found;
    logic [FRAME_NUM_W-1:0] frame_number;
    logic                   frame_bit;
  } alloc_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             in_action = '0;
  logic [START_W-1:0]     in_start_frame = '0;
  logic [END_W-1:0]       in_end_frame = '0;
  logic                   in_mark_value = 1'b0;
  logic [REQ_W-1:0]       in_request_bytes = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_found;
  logic [FRAME_NUM_W-1:0] out_frame_number;
  logic                   out_frame_bit;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [2:0]             paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  bit                     frame_used [MAX_FRAMES];
  int                     roving_ptr = 0;
  logic [FC_W-1:0]        frame_limit = FC_RESET;
  alloc_result_t          pending_results[$];
  alloc_result_t          want;
  int unsigned            src_idle_pct = 0;
  int unsigned            snk_stall_pct = 0;
  int unsigned            error_count = 0;
  int unsigned            cycle_count = 0;

  bitmap_frame_allocator #(
    .MAX_FRAMES (MAX_FRAMES),
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_start_frame  (in_start_frame),
    .in_end_frame    (in_end_frame),
    .in_mark_value   (in_mark_value),
    .in_request_bytes(in_request_bytes),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_frame_number(out_frame_number),
    .out_frame_bit   (out_frame_bit),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < snk_stall_pct);
  end

  // query, mark and next-fit / first-fit allocation on the shadow map
  function automatic alloc_result_t predict_alloc(input action_t act,
                                                  input logic [START_W-1:0] sf,
                                                  input logic [END_W-1:0] ef,
                                                  input logic mv,
                                                  input logic [REQ_W-1:0] nbytes);
    alloc_result_t r;
    int fc, s, lim, cur, need, run, first, i;
    r = '0;
    fc = int'(frame_limit);
    if (fc > MAX_FRAMES) fc = MAX_FRAMES;
    s = int'(sf);
    case (act)
      ACT_QUERY: begin
        r.frame_bit = frame_used[s];
      end
      ACT_MARK: begin
        lim = int'(ef);
        if (lim > MAX_FRAMES) lim = MAX_FRAMES;
        if (s < lim) begin
          for (i = s; i < lim; i++) frame_used[i] = mv;
          roving_ptr = lim - 1;
        end
      end
      ACT_ALLOC: begin
        cur = (roving_ptr < fc) ? roving_ptr : 0;
        for (i = 0; i < fc && !r.found; i++) begin
          if (!frame_used[cur]) begin
            frame_used[cur] = 1'b1;
            roving_ptr = cur;
            r.found = 1'b1;
            r.frame_number = FRAME_NUM_W'(cur);
          end else begin
            cur = (cur + 1 >= fc) ? 0 : cur + 1;
          end
        end
      end
      default: begin
        need = (int'(nbytes) + FRAME_BYTES - 1) / FRAME_BYTES;
        run = 0;
        first = 0;
        for (i = roving_ptr; i < fc && !r.found; i++) begin
          if (!frame_used[i]) begin
            if (run == 0) first = i;
            run++;
            if (run >= need) begin
              r.found = 1'b1;
              r.frame_number = FRAME_NUM_W'(first);
            end
          end else begin
            run = 0;
          end
        end
        if (r.found && need > 0) begin
          for (i = first; i < first + need; i++) frame_used[i] = 1'b1;
          roving_ptr = first + need - 1;
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string what, input logic [9:0] exp_v,
                             input logic [9:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch expected %0d actual %0d", $time, what, exp_v, got_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction expected none actual found=%0d frame=%0d bit=%0d",
                 $time, out_found, out_frame_number, out_frame_bit);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("found", 10'(want.found), 10'(out_found));
        check_field("frame_number", want.frame_number, out_frame_number);
        check_field("frame_bit", 10'(want.frame_bit), 10'(out_frame_bit));
      end
    end
  end

  task automatic send_item(input action_t act, input logic [START_W-1:0] sf,
                           input logic [END_W-1:0] ef, input logic mv,
                           input logic [REQ_W-1:0] nbytes);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid         <= 1'b1;
    in_action        <= act;
    in_start_frame   <= sf;
    in_end_frame     <= ef;
    in_mark_value    <= mv;
    in_request_bytes <= nbytes;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_alloc(act, sf, ef, mv, nbytes));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_frame_count(input logic [FC_W-1:0] value);
    wait_idle();
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {REG_FRAME_COUNT, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    frame_limit = value;
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[FC_W-1:0] !== value) begin
      $display("%0t: frame_count readback mismatch expected %0d actual %0d",
               $time, value, prdata[FC_W-1:0]);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed_basics();
    send_item(ACT_QUERY, 10'd0, 11'd0, 1'b0, 23'd0);
    send_item(ACT_QUERY, 10'd1023, 11'd0, 1'b0, 23'd0);
    send_item(ACT_ALLOC, 10'd0, 11'd0, 1'b0, 23'd0);
    send_item(ACT_ALLOC, 10'd0, 11'd0, 1'b0, 23'd0);
    send_item(ACT_RUN, 10'd0, 11'd0, 1'b0, 23'd1);
    send_item(ACT_RUN, 10'd0, 11'd0, 1'b0, 23'd4097);
    send_item(ACT_RUN, 10'd0, 11'd0, 1'b0, 23'd0);
    send_item(ACT_RUN, 10'd0, 11'd0, 1'b0, 23'h7fffff);
    send_item(ACT_MARK, 10'd0, 11'd2047, 1'b0, 23'd0);
    send_item(ACT_RUN, 10'd0, 11'd0, 1'b0, 23'd4096);
    send_item(ACT_ALLOC, 10'd0, 11'd0, 1'b0, 23'd0);
    send_item(ACT_MARK, 10'd0, 11'd1024, 1'b1, 23'd0);
    send_item(ACT_ALLOC, 10'd0, 11'd0, 1'b0, 23'd0);
    send_item(ACT_MARK, 10'd1023, 11'd5, 1'b1, 23'd0);
    send_item(ACT_MARK, 10'd512, 11'd513, 1'b0, 23'd0);
    send_item(ACT_QUERY, 10'd512, 11'd0, 1'b0, 23'd0);
    send_item(ACT_ALLOC, 10'd0, 11'd0, 1'b0, 23'd0);
  endtask

  task automatic test_frame_count_limits();
    write_frame_count(11'd0);
    send_item(ACT_ALLOC, 10'd0, 11'd0, 1'b0, 23'd0);
    send_item(ACT_RUN, 10'd0, 11'd0, 1'b0, 23'd0);
    write_frame_count(11'd1);
    send_item(ACT_MARK, 10'd0, 11'd1, 1'b0, 23'd0);
    send_item(ACT_ALLOC, 10'd0, 11'd0, 1'b0, 23'd0);
    send_item(ACT_ALLOC, 10'd0, 11'd0, 1'b0, 23'd0);
    write_frame_count(11'd2047);
    send_item(ACT_MARK, 10'd5, 11'd6, 1'b0, 23'd0);
    send_item(ACT_ALLOC, 10'd0, 11'd0, 1'b0, 23'd0);
    write_frame_count(11'd100);
    send_item(ACT_MARK, 10'd7, 11'd8, 1'b0, 23'd0);
    send_item(ACT_MARK, 10'd200, 11'd201, 1'b0, 23'd0);
    send_item(ACT_RUN, 10'd0, 11'd0, 1'b0, 23'd0);
    send_item(ACT_ALLOC, 10'd0, 11'd0, 1'b0, 23'd0);
  endtask

  task automatic send_random_item();
    int unsigned pick, shape;
    action_t act;
    logic [START_W-1:0] sf;
    logic [END_W-1:0] ef;
    logic mv;
    logic [REQ_W-1:0] nbytes;
    pick   = $urandom_range(99);
    shape  = $urandom_range(99);
    sf     = START_W'($urandom_range(1023));
    ef     = END_W'($urandom);
    mv     = ($urandom_range(99) < 40);
    nbytes = REQ_W'($urandom);
    if (pick < 15) begin
      act = ACT_QUERY;
    end else if (pick < 40) begin
      act = ACT_MARK;
      if (shape < 70) begin
        ef = END_W'(sf) + END_W'($urandom_range(48));
      end else if (shape < 80) begin
        sf = '0;
        ef = 11'd1024;
        mv = ($urandom_range(99) < 30);
      end else if (shape < 90) begin
        ef = END_W'($urandom_range(2047));
      end
    end else if (pick < 70) begin
      act = ACT_ALLOC;
    end else begin
      act = ACT_RUN;
      if (shape < 90) nbytes = REQ_W'($urandom_range(8 * FRAME_BYTES));
    end
    send_item(act, sf, ef, mv, nbytes);
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 0;
          snk_stall_pct = 0;
          write_frame_count(11'd1024);
        end
        1: begin
          src_idle_pct = 48;
          snk_stall_pct = 0;
          write_frame_count(FC_W'($urandom_range(1, 1024)));
        end
        2: begin
          src_idle_pct = 0;
          snk_stall_pct = 48;
          write_frame_count(FC_W'($urandom_range(1000, 2047)));
        end
        default: begin
          src_idle_pct = 36;
          snk_stall_pct = 36;
          write_frame_count(11'd1024);
        end
      endcase
      repeat (250) send_random_item();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_basics();
    test_frame_count_limits();
    test_random_traffic();
    wait_idle();
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
